// ===== hw/rtl/gac_pkg.sv =====
// Shared types and constants for the global alignment cost block.
package gac_pkg;

    localparam int BASE_W   = 2;
    localparam int GAP_W    = 4;
    localparam int SUB_W    = 64;
    localparam int DIST_W   = 13;
    localparam int DIST_MAX = 8191;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_COST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_TABLE = 1'b1;

    localparam logic [GAP_W-1:0] GAP_RESET = 4'd2;
    localparam logic [SUB_W-1:0] SUB_RESET = 64'h0444_4044_4404_4440;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW,
        ST_CELL,
        ST_FIN_RD,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic init_step;
        logic row_start;
        logic cell_step;
        logic row_next;
        logic fin_read;
        logic fin_load;
    } t_cmd;

    typedef struct packed {
        logic ovf_next;
        logic len1_zero;
        logic len2_zero;
        logic col_last;
        logic row_last;
        logic out_free;
    } t_stat;

endpackage

// ===== hw/rtl/gac_ram.sv =====
// Generic simple dual-port RAM with registered read.
module gac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/gac_dp.sv =====
// Datapath: base stores, score row, cell arithmetic, config and result registers.
module gac_dp #(
    parameter int MAX_LEN = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gac_pkg::t_cmd                 i_cmd,
    output gac_pkg::t_stat                o_stat,
    input  logic                          i_which_seq,
    input  logic [gac_pkg::BASE_W-1:0]    i_base,
    input  logic                          i_last,
    input  logic                          i_cfg_valid,
    input  logic [gac_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gac_pkg::SUB_W-1:0]     i_cfg_data,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [gac_pkg::DIST_W-1:0]    o_distance,
    output logic                          o_too_long
);
    import gac_pkg::*;

    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int RAW_W   = $clog2(2 * MAX_LEN * ((1 << GAP_W) - 1) + 1);
    localparam int SCORE_W = (RAW_W > DIST_W) ? RAW_W : DIST_W;
    localparam int SUM_W   = SCORE_W + 1;

    logic [GAP_W-1:0]   r_gap;
    logic [SUB_W-1:0]   r_sub;
    logic [LEN_W-1:0]   r_len1, r_len2;
    logic               r_ovf;
    logic [LEN_W-1:0]   r_i, r_j;
    logic [SCORE_W-1:0] r_acc, r_rowval, r_prevbase, r_diag, r_left;
    logic               r_out_valid;
    logic [DIST_W-1:0]  r_distance;
    logic               r_too_long;

    logic               w_room1, w_room2;
    logic               w_we1, w_we2;
    logic [BASE_W-1:0]  w_rd1, w_rd2;
    logic [ADDR_W-1:0]  w_raddr2;
    logic [LEN_W-1:0]   w_i_prev;
    logic               w_row_we, w_row_re;
    logic [LEN_W-1:0]   w_row_waddr, w_row_raddr;
    logic [SCORE_W-1:0] w_row_wdata, w_row_rd;
    logic [GAP_W-1:0]   w_sub_cost;
    logic [SUM_W-1:0]   w_c_diag, w_c_up, w_c_left, w_best;
    logic [SCORE_W-1:0] w_gap_ext;

    assign w_gap_ext = SCORE_W'(r_gap);
    assign w_room1   = r_len1 < LEN_W'(MAX_LEN);
    assign w_room2   = r_len2 < LEN_W'(MAX_LEN);
    assign w_we1     = i_cmd.accept && !i_which_seq && w_room1;
    assign w_we2     = i_cmd.accept && i_which_seq && w_room2;
    assign w_i_prev  = r_i - LEN_W'(1);
    assign w_raddr2  = i_cmd.cell_step ? r_j[ADDR_W-1:0] : '0;

    gac_ram #(.WIDTH(BASE_W), .DEPTH(MAX_LEN)) u_first (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (r_len1[ADDR_W-1:0]),
        .i_wdata (i_base),
        .i_re    (i_cmd.row_start),
        .i_raddr (w_i_prev[ADDR_W-1:0]),
        .o_rdata (w_rd1)
    );

    gac_ram #(.WIDTH(BASE_W), .DEPTH(MAX_LEN)) u_second (
        .i_clk   (i_clk),
        .i_we    (w_we2),
        .i_waddr (r_len2[ADDR_W-1:0]),
        .i_wdata (i_base),
        .i_re    (i_cmd.row_start || i_cmd.cell_step),
        .i_raddr (w_raddr2),
        .o_rdata (w_rd2)
    );

    // Cell: minimum of diagonal plus substitution, upper plus gap, left plus gap.
    assign w_sub_cost = GAP_W'(r_sub >> {w_rd1, w_rd2, 2'b00});
    assign w_c_diag   = SUM_W'(r_diag) + SUM_W'(w_sub_cost);
    assign w_c_up     = SUM_W'(w_row_rd) + SUM_W'(r_gap);
    assign w_c_left   = SUM_W'(r_left) + SUM_W'(r_gap);

    always_comb begin
        w_best = w_c_diag;
        if (w_c_up < w_best) begin
            w_best = w_c_up;
        end
        if (w_c_left < w_best) begin
            w_best = w_c_left;
        end
    end

    always_comb begin
        w_row_we    = 1'b0;
        w_row_waddr = r_j;
        w_row_wdata = r_acc;
        w_row_re    = 1'b0;
        w_row_raddr = r_len2;
        if (i_cmd.init_step) begin
            w_row_we = 1'b1;
        end
        if (i_cmd.row_start) begin
            w_row_we    = 1'b1;
            w_row_waddr = '0;
            w_row_wdata = r_rowval;
            w_row_re    = 1'b1;
            w_row_raddr = LEN_W'(1);
        end
        if (i_cmd.cell_step) begin
            w_row_we    = 1'b1;
            w_row_wdata = w_best[SCORE_W-1:0];
            w_row_re    = 1'b1;
            w_row_raddr = r_j + LEN_W'(1);
        end
        if (i_cmd.fin_read) begin
            w_row_re = 1'b1;
        end
    end

    gac_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_LEN + 1)) u_row (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (w_row_waddr),
        .i_wdata (w_row_wdata),
        .i_re    (w_row_re),
        .i_raddr (w_row_raddr),
        .o_rdata (w_row_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap       <= GAP_RESET;
            r_sub       <= SUB_RESET;
            r_len1      <= '0;
            r_len2      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_GAP_COST:  r_gap <= i_cfg_data[GAP_W-1:0];
                    CFG_SUB_TABLE: r_sub <= i_cfg_data;
                    default:       r_sub <= r_sub;
                endcase
            end
            if (i_cmd.accept) begin
                if (w_we1) begin
                    r_len1 <= r_len1 + LEN_W'(1);
                end
                if (w_we2) begin
                    r_len2 <= r_len2 + LEN_W'(1);
                end
                if ((!i_which_seq && !w_room1) || (i_which_seq && !w_room2)) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.fin_load) begin
                r_len1      <= '0;
                r_len2      <= '0;
                r_ovf       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_last) begin
            r_j   <= '0;
            r_acc <= '0;
        end
        if (i_cmd.init_step) begin
            r_j   <= r_j + LEN_W'(1);
            r_acc <= r_acc + w_gap_ext;
            if (r_j == r_len2) begin
                r_i        <= LEN_W'(1);
                r_rowval   <= w_gap_ext;
                r_prevbase <= '0;
            end
        end
        if (i_cmd.row_start) begin
            r_j    <= LEN_W'(1);
            r_left <= r_rowval;
            r_diag <= r_prevbase;
        end
        if (i_cmd.cell_step) begin
            r_j    <= r_j + LEN_W'(1);
            r_left <= w_best[SCORE_W-1:0];
            r_diag <= w_row_rd;
        end
        if (i_cmd.row_next) begin
            r_i        <= r_i + LEN_W'(1);
            r_prevbase <= r_rowval;
            r_rowval   <= r_rowval + w_gap_ext;
        end
        if (i_cmd.fin_load) begin
            r_too_long <= r_ovf;
            if (r_ovf) begin
                r_distance <= '0;
            end else if (w_row_rd > SCORE_W'(DIST_MAX)) begin
                r_distance <= DIST_W'(DIST_MAX);
            end else begin
                r_distance <= w_row_rd[DIST_W-1:0];
            end
        end
    end

    assign o_stat.ovf_next  = r_ovf || (!i_which_seq && !w_room1) || (i_which_seq && !w_room2);
    assign o_stat.len1_zero = r_len1 == '0;
    assign o_stat.len2_zero = r_len2 == '0;
    assign o_stat.col_last  = r_j == r_len2;
    assign o_stat.row_last  = r_i == r_len1;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;
    assign o_too_long  = r_too_long;

endmodule

// ===== hw/rtl/gac_ctrl.sv =====
// Controller: sequences base loading, row initialization, cell sweep and result load.
module gac_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_last,
    input  gac_pkg::t_stat i_stat,
    output gac_pkg::t_cmd  o_cmd,
    output logic           o_in_stall
);
    import gac_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_last) begin
                    n_state = i_stat.ovf_next ? ST_FIN : ST_INIT;
                end
            end
            ST_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_stat.col_last) begin
                    n_state = i_stat.len1_zero ? ST_FIN_RD : ST_ROW;
                end
            end
            ST_ROW: begin
                o_cmd.row_start = 1'b1;
                if (i_stat.len2_zero) begin
                    o_cmd.row_next = 1'b1;
                    n_state = i_stat.row_last ? ST_FIN_RD : ST_ROW;
                end else begin
                    n_state = ST_CELL;
                end
            end
            ST_CELL: begin
                o_cmd.cell_step = 1'b1;
                if (i_stat.col_last) begin
                    o_cmd.row_next = 1'b1;
                    n_state = i_stat.row_last ? ST_FIN_RD : ST_ROW;
                end
            end
            ST_FIN_RD: begin
                o_cmd.fin_read = 1'b1;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.fin_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/global_alignment_cost.sv =====
// Top level of the global alignment cost block (linear gap cost).
//
//  channel | direction | handshake                | payload
//  in      | input     | i_in_valid / o_in_stall  | i_which_seq, i_base, i_last
//  out     | output    | o_out_valid / i_out_stall| o_distance, o_too_long
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// Base beats are accepted one per cycle while idle. A beat with i_last set starts the
// table fill: the score row is seeded, then each of the n1 rows gets a row start and n2
// cells (one cell per cycle through the score-row RAM); then the bottom-right cell is
// read out. An overlong pair skips the fill. Reset is synchronous; the stores need no
// clearing pass. Input stalls during the fill; a pending result waits in the output
// register while new bases load.
module global_alignment_cost #(
    parameter int MAX_LEN = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_which_seq,
    input  logic [gac_pkg::BASE_W-1:0]    i_base,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gac_pkg::DIST_W-1:0]    o_distance,
    output logic                          o_too_long,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gac_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gac_pkg::SUB_W-1:0]     i_cfg_data
);
    import gac_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    gac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_last),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    gac_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_which_seq (i_which_seq),
        .i_base      (i_base),
        .i_last      (i_last),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_distance  (o_distance),
        .o_too_long  (o_too_long)
    );

endmodule

// ===== verif/global_alignment_cost_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for global_alignment_cost: random base pairs, cost settings, scoring.
module global_alignment_cost_test;
    import gac_pkg::*;

    localparam int MAX_LEN = 256;
    localparam int IDLE_LIMIT = 300_000;

    typedef struct {
        logic       which;
        logic [1:0] base;
        logic       last;
        bit         hold;
    } t_beat;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              too_long;
    } t_cost;

    logic                 i_clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_which = 1'b0;
    logic [BASE_W-1:0]    in_base = '0;
    logic                 in_last = 1'b0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SUB_W-1:0]     cfg_data = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [DIST_W-1:0]    o_distance;
    logic                 o_too_long;
    logic                 o_cfg_ready;

    t_beat beats_pending[$];
    t_cost costs_due[$];

    logic [GAP_W-1:0] gap_setting = GAP_RESET;
    logic [SUB_W-1:0] sub_setting = SUB_RESET;
    logic [1:0]       seq1_mem [MAX_LEN];
    logic [1:0]       seq2_mem [MAX_LEN];
    int               len1 = 0;
    int               len2 = 0;
    bit               overflowed = 1'b0;

    int errors = 0;
    int beats_taken = 0;
    int results_due = 0;
    int results_seen = 0;
    int pairs_queued = 0;
    int settings_used = 1;
    int gap_left = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    bit in_burst = 1'b0;
    bit out_burst = 1'b0;

    global_alignment_cost #(.MAX_LEN(MAX_LEN)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_which_seq (in_which),
        .i_base      (in_base),
        .i_last      (in_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_distance  (o_distance),
        .o_too_long  (o_too_long),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [DIST_W-1:0] align_cost();
        int row [0:MAX_LEN];
        int diag, up, best, c, k;
        for (int j = 0; j <= len2; j++) row[j] = j * int'(gap_setting);
        for (int i = 1; i <= len1; i++) begin
            diag = row[0];
            row[0] = i * int'(gap_setting);
            for (int j = 1; j <= len2; j++) begin
                up = row[j];
                k = int'(seq1_mem[i-1]) * 4 + int'(seq2_mem[j-1]);
                best = diag + int'(sub_setting[k*4 +: 4]);
                c = up + int'(gap_setting);
                if (c < best) best = c;
                c = row[j-1] + int'(gap_setting);
                if (c < best) best = c;
                diag = up;
                row[j] = best;
            end
        end
        if (row[len2] > DIST_MAX) return DIST_W'(DIST_MAX);
        return DIST_W'(row[len2]);
    endfunction

    function automatic void load_base(logic which, logic [1:0] b, logic last);
        t_cost cost;
        if (!which) begin
            if (len1 < MAX_LEN) begin
                seq1_mem[len1] = b;
                len1++;
            end else begin
                overflowed = 1'b1;
            end
        end else begin
            if (len2 < MAX_LEN) begin
                seq2_mem[len2] = b;
                len2++;
            end else begin
                overflowed = 1'b1;
            end
        end
        if (last) begin
            if (overflowed) begin
                cost.distance = '0;
                cost.too_long = 1'b1;
            end else begin
                cost.distance = align_cost();
                cost.too_long = 1'b0;
            end
            costs_due.push_back(cost);
            len1 = 0;
            len2 = 0;
            overflowed = 1'b0;
        end
    endfunction

    // Sender: hold payload while stalled, draw a gap after every beat.
    always @(posedge i_clk) begin : drive_bases
        t_beat nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                load_base(in_which, in_base, in_last);
                beats_taken++;
                if (in_last) results_due++;
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (beats_pending.size() != 0 &&
                             !(beats_pending[0].hold && results_seen != results_due)) begin
                    nxt = beats_pending.pop_front();
                    in_valid <= 1'b1;
                    in_which <= nxt.which;
                    in_base <= nxt.base;
                    in_last <= nxt.last;
                    if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
                    gap_left = in_burst ? 0 : $urandom_range(0, 4);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: compare each result beat, then draw how long to stall the next one.
    always @(posedge i_clk) begin : check_costs
        t_cost want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (o_out_valid && !out_stall) begin
            if (costs_due.size() == 0) begin
                $display("%0t: unexpected result distance=%0d too_long=%0b",
                         $time, o_distance, o_too_long);
                errors++;
            end else begin
                want = costs_due.pop_front();
                if (o_distance !== want.distance) begin
                    $display("%0t: distance expected %0d actual %0d",
                             $time, want.distance, o_distance);
                    errors++;
                end
                if (o_too_long !== want.too_long) begin
                    $display("%0t: too_long expected %0b actual %0b",
                             $time, want.too_long, o_too_long);
                    errors++;
                end
            end
            results_seen <= results_seen + 1;
            if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
            stall_left = out_burst ? 0 : $urandom_range(0, 4);
            out_stall <= (stall_left != 0);
        end else if (o_out_valid) begin
            stall_left--;
            if (stall_left <= 0) out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
                (cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no beat for %0d cycles, %0d results outstanding",
                             $time, idle_cycles, costs_due.size());
                    $display("global_alignment_cost: mismatch");
                    $finish;
                end
            end
        end
    end

    task automatic push_beat(logic which, logic [1:0] b, logic last);
        t_beat bt;
        bt.which = which;
        bt.base = b;
        bt.last = last;
        bt.hold = 1'b0;
        beats_pending.push_back(bt);
    endtask

    task automatic queue_pair(int n1, int n2, bit hold);
        logic [1:0] s1[$];
        logic [1:0] s2[$];
        t_beat bt;
        int r1, r2;
        bit similar, in_order;
        similar = $urandom_range(0, 1);
        in_order = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n1; k++) s1.push_back(2'($urandom_range(0, 3)));
        for (int k = 0; k < n2; k++) begin
            if (similar && k < n1 && $urandom_range(0, 4) != 0) s2.push_back(s1[k]);
            else s2.push_back(2'($urandom_range(0, 3)));
        end
        r1 = n1;
        r2 = n2;
        while (r1 + r2 > 0) begin
            if (r2 == 0 || (r1 != 0 && (in_order || $urandom_range(1, r1 + r2) <= r1))) begin
                bt.which = 1'b0;
                bt.base = s1.pop_front();
                r1--;
            end else begin
                bt.which = 1'b1;
                bt.base = s2.pop_front();
                r2--;
            end
            bt.last = (r1 + r2 == 0);
            bt.hold = hold;
            hold = 1'b0;
            beats_pending.push_back(bt);
        end
        pairs_queued++;
    endtask

    task automatic queue_random_pairs(int n_beats);
        int sent, n1, n2, r;
        sent = 0;
        while (sent < n_beats) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                n1 = $urandom_range(20, 48);
                n2 = $urandom_range(20, 48);
            end else if (r == 1) begin
                n1 = 0;
                n2 = $urandom_range(1, 10);
            end else if (r == 2) begin
                n1 = $urandom_range(1, 10);
                n2 = 0;
            end else begin
                n1 = $urandom_range(1, 10);
                n2 = $urandom_range(1, 10);
            end
            queue_pair(n1, n2, $urandom_range(0, 24) == 0);
            sent += n1 + n2;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (beats_pending.size() != 0 || in_valid || results_seen < results_due)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SUB_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_GAP_COST) gap_setting = val[GAP_W-1:0];
        else sub_setting = val;
        @(negedge i_clk);
    endtask

    task automatic set_costs(logic [GAP_W-1:0] gap, logic [SUB_W-1:0] subs);
        logic [SUB_W-1:0] gap_word;
        gap_word = {$urandom(), $urandom()};
        gap_word[GAP_W-1:0] = gap;
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_GAP_COST, gap_word);
            write_reg(CFG_SUB_TABLE, subs);
        end else begin
            write_reg(CFG_SUB_TABLE, subs);
            write_reg(CFG_GAP_COST, gap_word);
        end
        settings_used++;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        push_beat(1'b0, 2'd0, 1'b1);
        push_beat(1'b1, 2'd3, 1'b1);
        push_beat(1'b0, 2'd1, 1'b0);
        push_beat(1'b1, 2'd1, 1'b1);
        push_beat(1'b0, 2'd2, 1'b0);
        push_beat(1'b0, 2'd3, 1'b0);
        push_beat(1'b1, 2'd3, 1'b0);
        push_beat(1'b1, 2'd2, 1'b1);
        push_beat(1'b1, 2'd0, 1'b0);
        push_beat(1'b0, 2'd0, 1'b0);
        push_beat(1'b1, 2'd1, 1'b0);
        push_beat(1'b0, 2'd2, 1'b0);
        push_beat(1'b0, 2'd3, 1'b0);
        push_beat(1'b1, 2'd3, 1'b1);
        push_beat(1'b0, 2'd3, 1'b0);
        push_beat(1'b0, 2'd3, 1'b0);
        push_beat(1'b1, 2'd0, 1'b1);
        pairs_queued += 6;
        queue_random_pairs(60);
        wait_drained();

        set_costs('0, '0);
        queue_random_pairs(60);
        wait_drained();

        // Full-size pair, then one sequence past the limit.
        set_costs('1, '1);
        queue_pair(MAX_LEN, MAX_LEN, 1'b1);
        queue_pair(MAX_LEN + 1, 1, 1'b0);
        queue_random_pairs(40);
        wait_drained();

        set_costs(GAP_W'($urandom_range(0, 15)), {$urandom(), $urandom()});
        queue_pair(1, MAX_LEN + 1, 1'b1);
        queue_pair(MAX_LEN, 0, 1'b0);
        queue_random_pairs(60);
        wait_drained();

        repeat (3) begin
            set_costs(GAP_W'($urandom_range(0, 15)), {$urandom(), $urandom()});
            queue_random_pairs(30);
            wait_drained();
        end

        repeat (20) @(negedge i_clk);
        if (costs_due.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, costs_due.size());
            errors += costs_due.size();
        end
        $display("covered %0d base beats in %0d pairs, %0d results checked, %0d cost settings",
                 beats_taken, pairs_queued, results_seen, settings_used);
        $display("lengths from empty to %0d, overlong sequences on both sides, %0d errors",
                 MAX_LEN, errors);
        if (errors == 0) begin
            $display("global_alignment_cost: match");
        end else begin
            $display("global_alignment_cost: mismatch");
        end
        $finish;
    end

endmodule
